// ===== src/psdc_pkg.sv =====
// ============================================================================
// psdc_pkg
// Shared types and constants for the pairwise site distance counter.
// ============================================================================
package psdc_pkg;

    localparam int DEF_LANES     = 8;
    localparam int DEF_MAX_SITES = 65536;

    localparam int SYM_W   = 8;
    localparam int SITES_W = 64;
    localparam int LCNT_W  = 4;
    localparam int CNT_W   = 17;
    localparam int CNT_MAX = 131071;

    typedef struct packed {
        logic compared;
        logic differing;
    } t_lane_hit;

    typedef struct packed {
        logic [CNT_W-1:0] compared_sites;
        logic [CNT_W-1:0] differing_sites;
        logic [CNT_W-1:0] min_compared;
        logic [CNT_W-1:0] max_compared;
    } t_result;

endpackage

// ===== src/psdc_lane.sv =====
// ============================================================================
// psdc_lane
// One site compare: both symbols present, and whether they differ.
// ============================================================================
module psdc_lane (
    input  logic [psdc_pkg::SYM_W-1:0] i_sym_a,
    input  logic [psdc_pkg::SYM_W-1:0] i_sym_b,
    input  logic                       i_en,
    output psdc_pkg::t_lane_hit        o_hit
);
    import psdc_pkg::*;

    logic w_both;

    assign w_both          = i_en && (i_sym_a != '0) && (i_sym_b != '0);
    assign o_hit.compared  = w_both;
    assign o_hit.differing = w_both && (i_sym_a != i_sym_b);

endmodule

// ===== src/psdc_merge.sv =====
// ============================================================================
// psdc_merge
// Lane count merge, saturating pair accumulation, run min/max tracking,
// and the output register with a one-entry skid stage.
// ============================================================================
module psdc_merge #(
    parameter int LANES     = psdc_pkg::DEF_LANES,
    parameter int MAX_SITES = psdc_pkg::DEF_MAX_SITES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  psdc_pkg::t_lane_hit   i_hits [LANES],
    input  logic                  i_accept,
    input  logic                  i_last_chunk,
    input  logic                  i_start_of_run,
    input  logic                  i_stall,
    output logic                  o_full,
    output logic                  o_valid,
    output psdc_pkg::t_result     o_result
);
    import psdc_pkg::*;

    localparam int HCNT_W  = $clog2(LANES + 1);
    localparam int BOUND_I = (MAX_SITES < CNT_MAX) ? MAX_SITES : CNT_MAX;
    localparam logic [CNT_W:0] BOUND = (CNT_W + 1)'(BOUND_I);

    logic [HCNT_W-1:0] w_cmp_cnt;
    logic [HCNT_W-1:0] w_dif_cnt;
    logic [CNT_W-1:0]  w_cmp_base;
    logic [CNT_W-1:0]  w_dif_base;
    logic [CNT_W:0]    w_cmp_sum;
    logic [CNT_W:0]    w_dif_sum;
    logic [CNT_W-1:0]  w_cmp_sat;
    logic [CNT_W-1:0]  w_dif_sat;
    logic              w_have;
    t_result           w_res;
    logic              w_emit;
    logic              w_out_free;

    logic [CNT_W-1:0]  r_cmp_acc, n_cmp_acc;
    logic [CNT_W-1:0]  r_dif_acc, n_dif_acc;
    logic [CNT_W-1:0]  r_min, n_min;
    logic [CNT_W-1:0]  r_max, n_max;
    logic              r_have_pair, n_have_pair;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;
    t_result           r_skid, n_skid;
    logic              r_skid_valid, n_skid_valid;

    always_comb begin
        w_cmp_cnt = '0;
        w_dif_cnt = '0;
        for (int i = 0; i < LANES; i++) begin
            w_cmp_cnt = w_cmp_cnt + HCNT_W'(i_hits[i].compared);
            w_dif_cnt = w_dif_cnt + HCNT_W'(i_hits[i].differing);
        end
    end

    always_comb begin
        w_cmp_base = i_start_of_run ? '0 : r_cmp_acc;
        w_dif_base = i_start_of_run ? '0 : r_dif_acc;
        w_have     = i_start_of_run ? 1'b0 : r_have_pair;
        w_cmp_sum  = {1'b0, w_cmp_base} + (CNT_W + 1)'(w_cmp_cnt);
        w_dif_sum  = {1'b0, w_dif_base} + (CNT_W + 1)'(w_dif_cnt);
        w_cmp_sat  = (w_cmp_sum > BOUND) ? BOUND[CNT_W-1:0] : w_cmp_sum[CNT_W-1:0];
        w_dif_sat  = (w_dif_sum > BOUND) ? BOUND[CNT_W-1:0] : w_dif_sum[CNT_W-1:0];

        w_res.compared_sites  = w_cmp_sat;
        w_res.differing_sites = w_dif_sat;
        if (!w_have) begin
            w_res.min_compared = w_cmp_sat;
            w_res.max_compared = w_cmp_sat;
        end else begin
            w_res.min_compared = (w_cmp_sat < r_min) ? w_cmp_sat : r_min;
            w_res.max_compared = (w_cmp_sat > r_max) ? w_cmp_sat : r_max;
        end
    end

    assign w_emit     = i_accept && i_last_chunk;
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_cmp_acc    = r_cmp_acc;
        n_dif_acc    = r_dif_acc;
        n_min        = r_min;
        n_max        = r_max;
        n_have_pair  = r_have_pair;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;

        if (i_accept) begin
            if (i_last_chunk) begin
                n_cmp_acc   = '0;
                n_dif_acc   = '0;
                n_min       = w_res.min_compared;
                n_max       = w_res.max_compared;
                n_have_pair = 1'b1;
            end else begin
                n_cmp_acc   = w_cmp_sat;
                n_dif_acc   = w_dif_sat;
                n_have_pair = w_have;
            end
        end

        if (w_out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (w_emit) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_emit) begin
            n_skid       = w_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_acc    <= '0;
            r_dif_acc    <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_have_pair  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_cmp_acc    <= n_cmp_acc;
            r_dif_acc    <= n_dif_acc;
            r_min        <= n_min;
            r_max        <= n_max;
            r_have_pair  <= n_have_pair;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== src/pairwise_site_distance_counter.sv =====
// A result is registered (output or skid stage) when its last chunk transfers.
// Throughput: one chunk per cycle while o_stall is low; each lane compares
// one site; the merge stage counts lane hits and updates the pair and run registers.
// o_stall is registered: it rises only while the skid stage holds a result.
// Reset (synchronous, i_rst_n low) clears counts, run extremes and valid flags.
// ============================================================================
// pairwise_site_distance_counter
// Pairwise compared/differing site counts with run min/max of compared counts.
// ============================================================================
module pairwise_site_distance_counter #(
    parameter int LANES     = psdc_pkg::DEF_LANES,
    parameter int MAX_SITES = psdc_pkg::DEF_MAX_SITES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [psdc_pkg::SITES_W-1:0]  i_sites_a,
    input  logic [psdc_pkg::SITES_W-1:0]  i_sites_b,
    input  logic [psdc_pkg::LCNT_W-1:0]   i_lanes_valid,
    input  logic                          i_last_chunk,
    input  logic                          i_start_of_run,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [psdc_pkg::CNT_W-1:0]    o_compared_sites,
    output logic [psdc_pkg::CNT_W-1:0]    o_differing_sites,
    output logic [psdc_pkg::CNT_W-1:0]    o_min_compared,
    output logic [psdc_pkg::CNT_W-1:0]    o_max_compared
);
    import psdc_pkg::*;

    t_lane_hit w_hits [LANES];
    t_result   w_result;
    logic      w_accept;
    logic      w_full;

    assign w_accept = i_valid && !w_full;
    assign o_stall  = w_full;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        psdc_lane u_lane (
            .i_sym_a (i_sites_a[g*SYM_W +: SYM_W]),
            .i_sym_b (i_sites_b[g*SYM_W +: SYM_W]),
            .i_en    (i_lanes_valid > LCNT_W'(g)),
            .o_hit   (w_hits[g])
        );
    end

    psdc_merge #(
        .LANES     (LANES),
        .MAX_SITES (MAX_SITES)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hits         (w_hits),
        .i_accept       (w_accept),
        .i_last_chunk   (i_last_chunk),
        .i_start_of_run (i_start_of_run),
        .i_stall        (i_stall),
        .o_full         (w_full),
        .o_valid        (o_valid),
        .o_result       (w_result)
    );

    assign o_compared_sites  = w_result.compared_sites;
    assign o_differing_sites = w_result.differing_sites;
    assign o_min_compared    = w_result.min_compared;
    assign o_max_compared    = w_result.max_compared;

endmodule
